// ===== rtl/btbm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the block template best match engine: field widths, command codes,
// sequencer states and the control struct between the top level and the score unit.
// It depends on nothing else.
package btbm_pkg;

  localparam int CMD_W  = 1;
  localparam int TIDX_W = 7;
  localparam int PIDX_W = 6;
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 8;
  localparam int OUT_W  = 7;
  localparam int MUL_W  = 32;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 8'd94;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEMPLATE = 1'b0,
    CMD_SOURCE   = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_PP0,
    ST_PP1,
    ST_PP2,
    ST_DRAIN,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_SQD,
    MOP_SQ,
    MOP_LO,
    MOP_MID,
    MOP_HI
  } mop_t;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_SH0,
    TAG_SH33,
    TAG_SH64
  } acc_tag_t;

  typedef struct packed {
    mop_t mop;
    logic acc_clr;
  } score_ctrl_t;

endpackage

// ===== rtl/btbm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with a registered read.
// It depends on nothing else.
module btbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/btbm_score.sv =====
`timescale 1ns / 1ps
// Score unit: one shared 32x32 multiplier that raises a pixel difference to the 16th
// power by repeated squaring and accumulates the exact sum. Depends on btbm_pkg.
module btbm_score #(
  parameter int SCORE_W = 134
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btbm_pkg::score_ctrl_t         ctrl,
  input  logic [btbm_pkg::PIX_W-1:0]    src_pix,
  input  logic [btbm_pkg::PIX_W-1:0]    tpl_pix,
  output logic [SCORE_W-1:0]            acc
);

  localparam int MW = btbm_pkg::MUL_W;

  logic [btbm_pkg::PIX_W-1:0] diff;
  logic [MW-1:0]              op_a;
  logic [MW-1:0]              op_b;
  logic [2*MW-1:0]            prod_r;
  logic [2*MW-1:0]            prod_nxt;
  logic [2*MW-1:0]            d8_r;
  logic [2*MW-1:0]            d8_nxt;
  btbm_pkg::acc_tag_t         tag_r;
  btbm_pkg::acc_tag_t         tag_nxt;
  logic [SCORE_W-1:0]         acc_r;
  logic [SCORE_W-1:0]         acc_nxt;

  assign diff = (src_pix > tpl_pix) ? (src_pix - tpl_pix) : (tpl_pix - src_pix);

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    d8_nxt  = d8_r;
    tag_nxt = btbm_pkg::TAG_NONE;
    case (ctrl.mop)
      btbm_pkg::MOP_SQD: begin
        op_a = MW'(diff);
        op_b = MW'(diff);
      end
      btbm_pkg::MOP_SQ: begin
        op_a = prod_r[MW-1:0];
        op_b = prod_r[MW-1:0];
      end
      btbm_pkg::MOP_LO: begin
        op_a    = prod_r[MW-1:0];
        op_b    = prod_r[MW-1:0];
        d8_nxt  = prod_r;
        tag_nxt = btbm_pkg::TAG_SH0;
      end
      btbm_pkg::MOP_MID: begin
        op_a    = d8_r[MW-1:0];
        op_b    = d8_r[2*MW-1:MW];
        tag_nxt = btbm_pkg::TAG_SH33;
      end
      btbm_pkg::MOP_HI: begin
        op_a    = d8_r[2*MW-1:MW];
        op_b    = d8_r[2*MW-1:MW];
        tag_nxt = btbm_pkg::TAG_SH64;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_nxt = op_a * op_b;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else begin
      case (tag_r)
        btbm_pkg::TAG_SH0:  acc_nxt = acc_r + SCORE_W'(prod_r);
        btbm_pkg::TAG_SH33: acc_nxt = acc_r + (SCORE_W'(prod_r) << 33);
        btbm_pkg::TAG_SH64: acc_nxt = acc_r + (SCORE_W'(prod_r) << 64);
        default:            acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    d8_r   <= d8_nxt;
    if (!rst_n) begin
      tag_r <= btbm_pkg::TAG_NONE;
      acc_r <= '0;
    end else begin
      tag_r <= tag_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/block_template_best_match_top.sv =====
`timescale 1ns / 1ps
// Top level of the block template best match engine: request decode, search sequencer
// and best-score tracking. Depends on btbm_pkg, btbm_ram and btbm_score.
//
// Template pixel writes and source pixels other than the last position are accepted
// whenever busy is low and never raise busy. The source pixel at the last position
// starts a search that holds busy high while one shared 32x32 multiplier walks every
// active template: each pixel goes through one memory read (ST_RD), three squarings
// (ST_SQ1 to ST_SQ3) and three partial products (ST_PP0 to ST_PP2), and each template
// then passes ST_DRAIN to finish the sum and ST_CMP to compare it. After the last
// template, out_valid pulses in ST_DONE. The result is shown for exactly one cycle
// and the receiver cannot hold it off.
module block_template_best_match_top #(
  parameter int MAX_TEMPLATES = 128,
  parameter int BLOCK_SIZE    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [btbm_pkg::CMD_W-1:0]    in_command,
  input  logic [btbm_pkg::TIDX_W-1:0]   in_template_index,
  input  logic [btbm_pkg::PIDX_W-1:0]   in_pixel_index,
  input  logic [btbm_pkg::PIX_W-1:0]    in_pixel_value,
  input  logic                          cfg_we,
  input  logic [btbm_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  output logic [btbm_pkg::OUT_W-1:0]    out_best_template
);

  localparam int BLOCK_PIXELS = BLOCK_SIZE * BLOCK_SIZE;
  localparam int PIX_AW       = $clog2(BLOCK_PIXELS);
  localparam int STORE_DEPTH  = MAX_TEMPLATES * BLOCK_PIXELS;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(MAX_TEMPLATES + 1);
  localparam int SCORE_W      = 128 + PIX_AW;

  btbm_pkg::state_t             state_r;
  btbm_pkg::state_t             state_nxt;
  btbm_pkg::score_ctrl_t        ctrl;

  logic [btbm_pkg::CFG_W-1:0]   active_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CNT_W-1:0]             count_clamp;
  logic [CNT_W-1:0]             k_r;
  logic [CNT_W-1:0]             k_nxt;
  logic [STORE_AW-1:0]          base_r;
  logic [STORE_AW-1:0]          base_nxt;
  logic [PIX_AW-1:0]            p_r;
  logic [PIX_AW-1:0]            p_nxt;
  logic [SCORE_W-1:0]           best_r;
  logic [SCORE_W-1:0]           best_nxt;
  logic [btbm_pkg::OUT_W-1:0]   best_idx_r;
  logic [btbm_pkg::OUT_W-1:0]   best_idx_nxt;
  logic [SCORE_W-1:0]           acc;

  logic                         req;
  logic                         pix_ok;
  logic                         tpl_ok;
  logic                         tpl_we;
  logic                         blk_we;
  logic                         launch;
  logic                         p_last;
  logic                         k_last;
  logic [STORE_AW-1:0]          tpl_wr_addr;
  logic [STORE_AW-1:0]          tpl_addr;
  logic [PIX_AW-1:0]            blk_addr;
  logic [btbm_pkg::PIX_W-1:0]   tpl_pix;
  logic [btbm_pkg::PIX_W-1:0]   src_pix;

  assign busy   = (state_r != btbm_pkg::ST_IDLE);
  assign req    = start && !busy;
  assign pix_ok = (32'(in_pixel_index) < BLOCK_PIXELS);
  assign tpl_ok = (32'(in_template_index) < MAX_TEMPLATES);
  assign tpl_we = req && pix_ok && tpl_ok && (in_command == btbm_pkg::CMD_TEMPLATE);
  assign blk_we = req && pix_ok && (in_command == btbm_pkg::CMD_SOURCE);
  assign launch = blk_we && (32'(in_pixel_index) == BLOCK_PIXELS - 1);
  assign p_last = (p_r == PIX_AW'(BLOCK_PIXELS - 1));
  assign k_last = (k_r == count_r - CNT_W'(1));

  assign count_clamp = (32'(active_r) > MAX_TEMPLATES) ? CNT_W'(MAX_TEMPLATES)
                                                       : CNT_W'(active_r);

  assign tpl_wr_addr = STORE_AW'(STORE_AW'(in_template_index) * STORE_AW'(BLOCK_PIXELS))
                     + STORE_AW'(in_pixel_index);
  assign tpl_addr    = tpl_we ? tpl_wr_addr : (base_r + STORE_AW'(p_r));
  assign blk_addr    = blk_we ? PIX_AW'(in_pixel_index) : p_r;

  btbm_ram #(
    .WIDTH (btbm_pkg::PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_tpl_ram (
    .clk   (clk),
    .we    (tpl_we),
    .addr  (tpl_addr),
    .wdata (in_pixel_value),
    .rdata (tpl_pix)
  );

  btbm_ram #(
    .WIDTH (btbm_pkg::PIX_W),
    .DEPTH (BLOCK_PIXELS)
  ) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .addr  (blk_addr),
    .wdata (in_pixel_value),
    .rdata (src_pix)
  );

  btbm_score #(
    .SCORE_W (SCORE_W)
  ) u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .src_pix (src_pix),
    .tpl_pix (tpl_pix),
    .acc     (acc)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btbm_pkg::ST_IDLE: begin
        if (launch) begin
          state_nxt = (count_clamp == '0) ? btbm_pkg::ST_DONE : btbm_pkg::ST_RD;
        end
      end
      btbm_pkg::ST_RD:    state_nxt = btbm_pkg::ST_SQ1;
      btbm_pkg::ST_SQ1:   state_nxt = btbm_pkg::ST_SQ2;
      btbm_pkg::ST_SQ2:   state_nxt = btbm_pkg::ST_SQ3;
      btbm_pkg::ST_SQ3:   state_nxt = btbm_pkg::ST_PP0;
      btbm_pkg::ST_PP0:   state_nxt = btbm_pkg::ST_PP1;
      btbm_pkg::ST_PP1:   state_nxt = btbm_pkg::ST_PP2;
      btbm_pkg::ST_PP2:   state_nxt = p_last ? btbm_pkg::ST_DRAIN : btbm_pkg::ST_RD;
      btbm_pkg::ST_DRAIN: state_nxt = btbm_pkg::ST_CMP;
      btbm_pkg::ST_CMP:   state_nxt = k_last ? btbm_pkg::ST_DONE : btbm_pkg::ST_RD;
      btbm_pkg::ST_DONE:  state_nxt = btbm_pkg::ST_IDLE;
      default:            state_nxt = btbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.mop     = btbm_pkg::MOP_NONE;
    ctrl.acc_clr = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      btbm_pkg::ST_IDLE: ctrl.acc_clr = 1'b1;
      btbm_pkg::ST_SQ1:  ctrl.mop = btbm_pkg::MOP_SQD;
      btbm_pkg::ST_SQ2:  ctrl.mop = btbm_pkg::MOP_SQ;
      btbm_pkg::ST_SQ3:  ctrl.mop = btbm_pkg::MOP_SQ;
      btbm_pkg::ST_PP0:  ctrl.mop = btbm_pkg::MOP_LO;
      btbm_pkg::ST_PP1:  ctrl.mop = btbm_pkg::MOP_MID;
      btbm_pkg::ST_PP2:  ctrl.mop = btbm_pkg::MOP_HI;
      btbm_pkg::ST_CMP:  ctrl.acc_clr = 1'b1;
      btbm_pkg::ST_DONE: out_valid = 1'b1;
      default: begin
        ctrl.mop     = btbm_pkg::MOP_NONE;
        ctrl.acc_clr = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    k_nxt        = k_r;
    base_nxt     = base_r;
    p_nxt        = p_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    case (state_r)
      btbm_pkg::ST_IDLE: begin
        if (launch) begin
          count_nxt    = count_clamp;
          k_nxt        = '0;
          base_nxt     = '0;
          p_nxt        = '0;
          best_nxt     = '1;
          best_idx_nxt = '0;
        end
      end
      btbm_pkg::ST_PP2: begin
        p_nxt = p_last ? '0 : p_r + PIX_AW'(1);
      end
      btbm_pkg::ST_CMP: begin
        if (acc < best_r) begin
          best_nxt     = acc;
          best_idx_nxt = btbm_pkg::OUT_W'(k_r);
        end
        k_nxt    = k_r + CNT_W'(1);
        base_nxt = base_r + STORE_AW'(BLOCK_PIXELS);
      end
      default: begin
        p_nxt = p_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    base_r  <= base_nxt;
    if (!rst_n) begin
      state_r    <= btbm_pkg::ST_IDLE;
      active_r   <= btbm_pkg::ACTIVE_RESET;
      k_r        <= '0;
      p_r        <= '0;
      best_r     <= '1;
      best_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      p_r        <= p_nxt;
      best_r     <= best_nxt;
      best_idx_r <= best_idx_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
  end

  assign out_best_template = best_idx_r;

endmodule
